// ===== rtl/sfp_pkg.sv =====
// Package for the header/length/payload frame parser with 8-bit sum.
// Holds widths, register indexes, the controller state type and the
// command and status structs shared by the controller and the datapath.
package sfp_pkg;

  // Payload store depth and derived widths.
  localparam int unsigned MaxPayload = 64;
  localparam int unsigned AddrW      = $clog2(MaxPayload);
  localparam int unsigned LenW       = 7;
  localparam int unsigned ByteW      = 8;

  // Configuration port.
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = 8;
  localparam logic [CfgIdxW-1:0] RegHeaderByte    = 1'd0;
  localparam logic [CfgIdxW-1:0] RegMaxPayloadLen = 1'd1;
  localparam logic [ByteW-1:0]   HeaderByteReset  = 8'd239;
  localparam logic [LenW-1:0]    MaxLenReset      = 7'd64;

  // Controller states.
  typedef enum logic [3:0] {
    ST_WAIT_HDR,
    ST_DEVICE,
    ST_SYSTEM,
    ST_MESSAGE,
    ST_SEQUENCE,
    ST_LENGTH,
    ST_PAYLOAD,
    ST_CHECKSUM,
    ST_READ,
    ST_LOAD,
    ST_EMPTY
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;
    logic cap_device;
    logic cap_system;
    logic cap_message;
    logic cap_sequence;
    logic cap_length;
    logic store_payload;
    logic clr_drain;
    logic load_payload;
    logic load_empty;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic hdr_match;
    logic len_in_zero;
    logic len_in_over;
    logic payload_done;
    logic sum_match;
    logic frame_empty;
    logic drain_last;
    logic out_free;
  } status_t;

endpackage

// ===== rtl/sfp_ctrl.sv =====
// Controller state machine for the frame parser.
// Depends on sfp_pkg; drives datapath commands and the input ready.
module sfp_ctrl
  import sfp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;
  logic   fire;

  assign fire = in_valid & in_ready;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_WAIT_HDR;
    end else begin
      state <= state_next;
    end
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      ST_WAIT_HDR: begin
        if (fire && status.hdr_match) state_next = ST_DEVICE;
      end
      ST_DEVICE: begin
        if (fire) state_next = ST_SYSTEM;
      end
      ST_SYSTEM: begin
        if (fire) state_next = ST_MESSAGE;
      end
      ST_MESSAGE: begin
        if (fire) state_next = ST_SEQUENCE;
      end
      ST_SEQUENCE: begin
        if (fire) state_next = ST_LENGTH;
      end
      ST_LENGTH: begin
        if (fire) begin
          if (status.len_in_zero) state_next = ST_CHECKSUM;
          else if (status.len_in_over) state_next = ST_WAIT_HDR;
          else state_next = ST_PAYLOAD;
        end
      end
      ST_PAYLOAD: begin
        if (fire && status.payload_done) state_next = ST_CHECKSUM;
      end
      ST_CHECKSUM: begin
        if (fire) begin
          if (!status.sum_match) state_next = ST_WAIT_HDR;
          else if (status.frame_empty) state_next = ST_EMPTY;
          else state_next = ST_READ;
        end
      end
      ST_READ: begin
        state_next = ST_LOAD;
      end
      ST_LOAD: begin
        if (status.out_free) state_next = status.drain_last ? ST_WAIT_HDR : ST_READ;
      end
      ST_EMPTY: begin
        if (status.out_free) state_next = ST_WAIT_HDR;
      end
      default: begin
        state_next = ST_WAIT_HDR;
      end
    endcase
  end

  // Output decode: input ready and datapath commands. In every parsing
  // state the input is ready, so a beat is taken whenever valid is high.
  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    case (state)
      ST_WAIT_HDR: begin
        in_ready  = 1'b1;
        cmd.start = in_valid & status.hdr_match;
      end
      ST_DEVICE: begin
        in_ready       = 1'b1;
        cmd.cap_device = in_valid;
      end
      ST_SYSTEM: begin
        in_ready       = 1'b1;
        cmd.cap_system = in_valid;
      end
      ST_MESSAGE: begin
        in_ready        = 1'b1;
        cmd.cap_message = in_valid;
      end
      ST_SEQUENCE: begin
        in_ready         = 1'b1;
        cmd.cap_sequence = in_valid;
      end
      ST_LENGTH: begin
        in_ready       = 1'b1;
        cmd.cap_length = in_valid;
      end
      ST_PAYLOAD: begin
        in_ready          = 1'b1;
        cmd.store_payload = in_valid;
      end
      ST_CHECKSUM: begin
        in_ready      = 1'b1;
        cmd.clr_drain = in_valid;
      end
      ST_READ: begin
        in_ready = 1'b0;
      end
      ST_LOAD: begin
        cmd.load_payload = status.out_free;
      end
      ST_EMPTY: begin
        cmd.load_empty = status.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// ===== rtl/sfp_datapath.sv =====
// Datapath for the frame parser: config registers, header fields, running
// sum, payload store and the output register. Depends on sfp_pkg.
module sfp_datapath
  import sfp_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  input  logic [ByteW-1:0]    rx_byte,
  input  cmd_t                cmd,
  output status_t             status,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [ByteW-1:0]    device_id,
  output logic [ByteW-1:0]    system_id,
  output logic [ByteW-1:0]    message_id,
  output logic [ByteW-1:0]    sequence_res,
  output logic [LenW-1:0]     payload_len,
  output logic                payload_present,
  output logic [AddrW-1:0]    byte_index,
  output logic [ByteW-1:0]    payload_byte,
  output logic                last
);

  logic [ByteW-1:0] header_byte;
  logic [LenW-1:0]  max_payload_len;
  logic [ByteW-1:0] frame_device;
  logic [ByteW-1:0] frame_system;
  logic [ByteW-1:0] frame_message;
  logic [ByteW-1:0] frame_sequence;
  logic [LenW-1:0]  frame_length;
  logic [LenW-1:0]  payload_count;
  logic [ByteW-1:0] running_sum;
  logic [AddrW-1:0] drain_idx;
  logic [ByteW-1:0] rd_data;
  logic [ByteW-1:0] payload_store [MaxPayload];
  logic [LenW-1:0]  count_inc;
  logic [LenW-1:0]  drain_inc;
  logic             add_byte;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      header_byte     <= HeaderByteReset;
      max_payload_len <= MaxLenReset;
    end else if (cfg_we) begin
      case (cfg_index)
        RegHeaderByte:    header_byte     <= cfg_data;
        RegMaxPayloadLen: max_payload_len <= cfg_data[LenW-1:0];
        default: begin
          header_byte <= header_byte;
        end
      endcase
    end
  end

  // Header field capture.
  always_ff @(posedge clk) begin
    if (cmd.cap_device)   frame_device   <= rx_byte;
    if (cmd.cap_system)   frame_system   <= rx_byte;
    if (cmd.cap_message)  frame_message  <= rx_byte;
    if (cmd.cap_sequence) frame_sequence <= rx_byte;
    if (cmd.cap_length && !status.len_in_over) frame_length <= rx_byte[LenW-1:0];
  end

  // Running checksum over the header and payload bytes.
  assign add_byte = cmd.cap_device | cmd.cap_system | cmd.cap_message |
                    cmd.cap_sequence | cmd.cap_length | cmd.store_payload;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      running_sum <= rx_byte;
    end else if (add_byte) begin
      running_sum <= running_sum + rx_byte;
    end
  end

  // Payload byte counter.
  assign count_inc = payload_count + 7'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      payload_count <= '0;
    end else if (cmd.start || cmd.cap_length) begin
      payload_count <= '0;
    end else if (cmd.store_payload) begin
      payload_count <= count_inc;
    end
  end

  // Payload store: written while parsing, read while draining.
  always_ff @(posedge clk) begin
    if (cmd.store_payload) begin
      payload_store[payload_count[AddrW-1:0]] <= rx_byte;
    end
    rd_data <= payload_store[drain_idx];
  end

  // Drain index.
  assign drain_inc = {1'b0, drain_idx} + 7'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      drain_idx <= '0;
    end else if (cmd.clr_drain) begin
      drain_idx <= '0;
    end else if (cmd.load_payload) begin
      drain_idx <= drain_inc[AddrW-1:0];
    end
  end

  // Output register; holds its own copy of the frame fields.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_payload || cmd.load_empty) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_payload || cmd.load_empty) begin
      device_id       <= frame_device;
      system_id       <= frame_system;
      message_id      <= frame_message;
      sequence_res    <= frame_sequence;
      payload_len     <= frame_length;
      payload_present <= cmd.load_payload;
      byte_index      <= cmd.load_payload ? drain_idx : '0;
      payload_byte    <= cmd.load_payload ? rd_data : '0;
      last            <= cmd.load_empty | (drain_inc == frame_length);
    end
  end

  // Status to the controller.
  always_comb begin
    status.hdr_match    = (rx_byte == header_byte);
    status.len_in_zero  = (rx_byte == '0);
    status.len_in_over  = (rx_byte > {1'b0, max_payload_len}) ||
                          (rx_byte > ByteW'(MaxPayload));
    status.payload_done = (count_inc >= frame_length);
    status.sum_match    = (rx_byte == running_sum);
    status.frame_empty  = (frame_length == '0);
    status.drain_last   = (drain_inc == frame_length);
    status.out_free     = ~out_valid | out_ready;
  end

endmodule

// ===== rtl/sensor_frame_parser_sum8_core.sv =====
// Top level of the header/length/payload frame parser with 8-bit sum.
// Depends on sfp_pkg, sfp_ctrl and sfp_datapath.
//
//   Channel  Handshake             Beat contents
//   input    in_valid / in_ready   rx_byte
//   output   out_valid / out_ready device_id .. last (one payload byte)
//   config   cfg_we (no wait)      cfg_index, cfg_data
//
// While parsing, one input beat is taken per cycle.
// After a good checksum the input stalls while the payload drains: a store
// read, then the output register, per byte; an empty frame skips the read.
// The output register lets the next frame start while the last result waits.
// Reset idles the controller, clears the counters and output valid, and
// returns the config registers to their default values.
module sensor_frame_parser_sum8_core
  import sfp_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [ByteW-1:0]    rx_byte,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [ByteW-1:0]    device_id,
  output logic [ByteW-1:0]    system_id,
  output logic [ByteW-1:0]    message_id,
  output logic [ByteW-1:0]    sequence_res,
  output logic [LenW-1:0]     payload_len,
  output logic                payload_present,
  output logic [AddrW-1:0]    byte_index,
  output logic [ByteW-1:0]    payload_byte,
  output logic                last
);

  cmd_t    cmd;
  status_t status;

  // Controller.
  sfp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath.
  sfp_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .rx_byte         (rx_byte),
    .cmd             (cmd),
    .status          (status),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .device_id       (device_id),
    .system_id       (system_id),
    .message_id      (message_id),
    .sequence_res    (sequence_res),
    .payload_len     (payload_len),
    .payload_present (payload_present),
    .byte_index      (byte_index),
    .payload_byte    (payload_byte),
    .last            (last)
  );

endmodule
